### src/etm_pkg.sv
// Shared widths, operation codes and constants of the EMA throughput meter.
package etm_pkg;

  localparam int COUNT_W = 24;
  localparam int TIME_W = 32;
  localparam int SPEED_W = 31;
  localparam int TOTAL_W = 64;
  localparam int WINDOW_COUNT_WIDTH_DEF = 48;

  localparam int MUL_SCALE = 1000;
  localparam int MUL_SCALE_BITS = 10;
  localparam int DEN_W = TIME_W + 4;
  localparam int LAST9_W = SPEED_W + 4;
  localparam int CNT_W = 5;

  localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

endpackage

### src/ema_throughput_meter_core.sv
// Two-direction byte-rate meter with an integer exponential moving average speed estimate.
//
// channel | dir | tdata (low bit first)               | tuser (low bit first)
// in_     | in  | byte_count[23:0], now_ms[55:24]     | operation[0], direction[1]
// out_    | out | speed[30:0], total_bytes[94:31]     | -
//
// Add transfer: after accept, one saturating add step (ST_ADD), then ST_FIN loads the result.
// Sample transfer: one shared adder/subtractor runs a 10-step and a 32-step shift-add
// multiply, then a 32-step restoring divide that ends at its first step when the speed saturates.
// in_tready is high only while the sequencer is idle; a result held in the
// output register does not block the next accept, but the next result waits for it.
// Reset (synchronous, active low) clears all per-direction state to zero.
module ema_throughput_meter_core
  import etm_pkg::*;
#(
  parameter int WINDOW_COUNT_WIDTH = WINDOW_COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // byte_count[23:0], now_ms[55:24]
  input  logic [1:0]  in_tuser,   // operation[0], direction[1]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata   // speed[30:0], total_bytes[94:31], zero[95]
);

  localparam int WCW = WINDOW_COUNT_WIDTH;
  localparam int NUM_W = ((WCW + MUL_SCALE_BITS > 67) ? WCW + MUL_SCALE_BITS : 67) + 1;
  localparam logic [CNT_W-1:0] BIT_TOP = '1;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_ADD   = 7'b0000010,
    ST_SETUP = 7'b0000100,
    ST_MUL1  = 7'b0001000,
    ST_MUL2  = 7'b0010000,
    ST_DIV   = 7'b0100000,
    ST_FIN   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [SPEED_W-1:0] speed_est_r [2];
  logic [WCW-1:0]     win_r [2];
  logic [TOTAL_W-1:0] total_r [2];
  logic [TIME_W-1:0]  start_r [2];

  logic               dir_r;
  logic [COUNT_W-1:0] cnt_in_r;
  logic [TIME_W-1:0]  now_r;
  logic [TIME_W-1:0]  elapsed_r;
  logic [LAST9_W-1:0] last9_r;
  logic [DEN_W-1:0]   den_r;
  logic [NUM_W-1:0]   ma_r;
  logic [TIME_W-1:0]  mb_r;
  logic [NUM_W-1:0]   rem_r;
  logic [NUM_W-1:0]   dsh_r;
  logic [SPEED_W-1:0] q_r;
  logic [CNT_W-1:0]   cnt_r;

  logic               out_valid_r;
  logic [SPEED_W-1:0] out_speed_r;
  logic [TOTAL_W-1:0] out_total_r;

  // shared adder / subtractor
  logic             add_sub;
  logic [NUM_W-1:0] add_b;
  logic [NUM_W:0]   add_sum;
  logic             ge;

  logic [WCW:0]       win_sum;
  logic [WCW-1:0]     win_sat;
  logic [TIME_W-1:0]  diff;
  logic               div_done;
  logic [SPEED_W-1:0] speed_new;
  logic               slot_free;

  assign add_sub = (state_r == ST_DIV);
  assign add_b = add_sub ? dsh_r : (mb_r[0] ? ma_r : '0);
  assign add_sum = {1'b0, rem_r} + {1'b0, (add_sub ? ~add_b : add_b)}
                 + {{NUM_W{1'b0}}, add_sub};
  assign ge = add_sum[NUM_W];

  assign win_sum = {1'b0, win_r[dir_r]} + (WCW+1)'(cnt_in_r);
  assign win_sat = win_sum[WCW] ? '1 : win_sum[WCW-1:0];
  assign diff = now_r - start_r[dir_r];
  assign div_done = (cnt_r == BIT_TOP && ge) || (cnt_r == '0);
  assign speed_new = (cnt_r == BIT_TOP) ? SPEED_MAX : {q_r[SPEED_W-1:1], ge};
  assign slot_free = !out_valid_r || out_tready;

  assign in_tready = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata = {1'b0, out_total_r, out_speed_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (op_t'(in_tuser[0]) == OP_SAMPLE) ? ST_SETUP : ST_ADD;
        end
      end
      ST_ADD:   state_nxt = ST_FIN;
      ST_SETUP: state_nxt = ST_MUL1;
      ST_MUL1: begin
        if (cnt_r == '0) state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        if (cnt_r == '0) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int d = 0; d < 2; d++) begin
        speed_est_r[d] <= '0;
        win_r[d] <= '0;
        total_r[d] <= '0;
        start_r[d] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_FIN && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_ADD) begin
        win_r[dir_r] <= win_sat;
        total_r[dir_r] <= total_r[dir_r] + TOTAL_W'(cnt_in_r);
      end
      if (state_r == ST_DIV && div_done) begin
        speed_est_r[dir_r] <= speed_new;
        win_r[dir_r] <= '0;
        start_r[dir_r] <= now_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          dir_r <= in_tuser[1];
          cnt_in_r <= in_tdata[COUNT_W-1:0];
          now_r <= in_tdata[COUNT_W+TIME_W-1:COUNT_W];
        end
      end
      ST_SETUP: begin
        elapsed_r <= (diff == '0) ? TIME_W'(1) : diff;
        last9_r <= LAST9_W'({speed_est_r[dir_r], 3'b000}) + LAST9_W'(speed_est_r[dir_r]);
        ma_r <= NUM_W'(win_r[dir_r]);
        mb_r <= TIME_W'(MUL_SCALE);
        rem_r <= '0;
        cnt_r <= CNT_W'(MUL_SCALE_BITS - 1);
      end
      ST_MUL1: begin
        rem_r <= add_sum[NUM_W-1:0];
        if (cnt_r == '0) begin
          ma_r <= NUM_W'(last9_r);
          mb_r <= elapsed_r;
          cnt_r <= BIT_TOP;
          den_r <= DEN_W'({elapsed_r, 3'b000}) + DEN_W'({elapsed_r, 1'b0});
        end else begin
          ma_r <= ma_r << 1;
          mb_r <= mb_r >> 1;
          cnt_r <= cnt_r - 1'b1;
        end
      end
      ST_MUL2: begin
        rem_r <= add_sum[NUM_W-1:0];
        if (cnt_r == '0) begin
          dsh_r <= NUM_W'(den_r) << (SPEED_W);
          cnt_r <= BIT_TOP;
          q_r <= '0;
        end else begin
          ma_r <= ma_r << 1;
          mb_r <= mb_r >> 1;
          cnt_r <= cnt_r - 1'b1;
        end
      end
      ST_DIV: begin
        if (ge && cnt_r != BIT_TOP) begin
          rem_r <= add_sum[NUM_W-1:0];
          q_r[cnt_r] <= 1'b1;
        end
        dsh_r <= dsh_r >> 1;
        cnt_r <= cnt_r - 1'b1;
      end
      ST_FIN: begin
        if (slot_free) begin
          out_speed_r <= speed_est_r[dir_r];
          out_total_r <= total_r[dir_r];
        end
      end
      default: begin
      end
    endcase
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_ADD || state_r == ST_SETUP))
    else $error("accepted transfer did not start work");

  a_fin_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && slot_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finished result not presented");

  a_sample_clears_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && div_done) |=> (win_r[dir_r] == '0))
    else $error("window not cleared after sample");

  a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && cnt_r != BIT_TOP) |-> ({1'b0, rem_r} < {dsh_r, 1'b0}))
    else $error("divide remainder out of range");

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking stream testbench for the two-direction EMA throughput meter core.
module testbench;
  import etm_pkg::*;

  localparam int WIN_W = WINDOW_COUNT_WIDTH_DEF;
  localparam int STALL_PCT = 7;
  localparam int RANDOM_ITEMS = 1550;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct {
    op_t                op;
    logic               dir;
    logic [COUNT_W-1:0] bytes;
    logic [TIME_W-1:0]  now_ms;
  } meter_item_t;

  typedef struct {
    logic [SPEED_W-1:0] speed;
    logic [TOTAL_W-1:0] total;
  } meter_reading_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;   // byte_count[23:0], now_ms[55:24]
  logic [1:0]  in_tuser;   // operation[0], direction[1]
  logic        out_tvalid;
  logic        out_tready;
  logic [95:0] out_tdata;  // speed[30:0], total_bytes[94:31], zero[95]

  // per-direction meter state of the predictor
  logic [SPEED_W-1:0] est_speed[2];
  logic [WIN_W-1:0]   win_bytes[2];
  logic [TOTAL_W-1:0] total_bytes[2];
  logic [TIME_W-1:0]  win_start[2];

  meter_item_t    pending_items[$];
  meter_item_t    in_flight;
  meter_reading_t expected_readings[$];
  meter_reading_t got;
  meter_reading_t want;

  int items_sent;
  int readings_seen;
  int failures;
  int quiet_cycles;

  ema_throughput_meter_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  function automatic meter_reading_t update_meter(meter_item_t it);
    logic [WIN_W:0]     wsum;
    logic [TIME_W-1:0]  elapsed;
    logic [127:0]       num;
    logic [127:0]       den;
    logic [127:0]       quot;
    meter_reading_t     r;
    int                 d;
    d = int'(it.dir);
    if (it.op == OP_ADD) begin
      wsum = {1'b0, win_bytes[d]} + (WIN_W+1)'(it.bytes);
      win_bytes[d] = wsum[WIN_W] ? '1 : wsum[WIN_W-1:0];
      total_bytes[d] = total_bytes[d] + TOTAL_W'(it.bytes);
    end else begin
      elapsed = it.now_ms - win_start[d];
      if (elapsed == 0) elapsed = 1;
      num = 128'(win_bytes[d]) * 128'd1000
          + 128'd9 * 128'(est_speed[d]) * 128'(elapsed);
      den = 128'd10 * 128'(elapsed);
      quot = num / den;
      est_speed[d] = (quot > 128'(SPEED_MAX)) ? SPEED_MAX : quot[SPEED_W-1:0];
      win_start[d] = it.now_ms;
      win_bytes[d] = '0;
    end
    r.speed = est_speed[d];
    r.total = total_bytes[d];
    return r;
  endfunction

  task automatic queue_item(op_t op, logic dir, logic [COUNT_W-1:0] bytes,
                            logic [TIME_W-1:0] now_ms);
    meter_item_t it;
    it.op = op;
    it.dir = dir;
    it.bytes = bytes;
    it.now_ms = now_ms;
    pending_items.push_back(it);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        expected_readings.push_back(update_meter(in_flight));
        items_sent++;
      end
      if (pending_items.size() > 0 &&
          ((items_sent >= 700 && items_sent < 1000) || $urandom_range(99) >= STALL_PCT)) begin
        in_flight = pending_items.pop_front();
        in_tdata <= {in_flight.now_ms, in_flight.bytes};
        in_tuser <= {in_flight.dir, in_flight.op};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.speed = out_tdata[SPEED_W-1:0];
        got.total = out_tdata[SPEED_W +: TOTAL_W];
        readings_seen++;
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected transfer speed=%0d total=%0d",
                   $time, got.speed, got.total);
          failures++;
        end else begin
          want = expected_readings.pop_front();
          if (got.speed !== want.speed) begin
            $display("%0t: speed mismatch expected=%0d actual=%0d",
                     $time, want.speed, got.speed);
            failures++;
          end
          if (got.total !== want.total) begin
            $display("%0t: total_bytes mismatch expected=%0d actual=%0d",
                     $time, want.total, got.total);
            failures++;
          end
        end
      end
      out_tready <= (readings_seen >= 650 && readings_seen < 950) ||
                    $urandom_range(99) >= STALL_PCT;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog timeout", $time);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [TIME_W-1:0]  clock_ms[2];
    logic [TIME_W-1:0]  step;
    logic [COUNT_W-1:0] bytes;
    logic               d;
    logic               dir_sel;
    int                 burst;
    int                 pick;
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    items_sent = 0;
    readings_seen = 0;
    failures = 0;
    quiet_cycles = 0;
    for (int i = 0; i < 2; i++) begin
      est_speed[i] = '0;
      win_bytes[i] = '0;
      total_bytes[i] = '0;
      win_start[i] = '0;
    end

    // directed: zero elapsed, saturation, decay, max elapsed, timer wrap
    queue_item(OP_SAMPLE, 1'b0, 24'h000000, 32'h0000_0000);
    queue_item(OP_ADD, 1'b0, 24'hFFFFFF, 32'hFFFF_FFFF);
    queue_item(OP_ADD, 1'b0, 24'hFFFFFF, 32'hFFFF_FFFF);
    queue_item(OP_ADD, 1'b0, 24'hFFFFFF, 32'hFFFF_FFFF);
    queue_item(OP_SAMPLE, 1'b0, 24'h000000, 32'h0000_0001);
    queue_item(OP_SAMPLE, 1'b0, 24'hFFFFFF, 32'h0000_0001);
    queue_item(OP_ADD, 1'b1, 24'h000000, 32'h0000_0000);
    queue_item(OP_ADD, 1'b1, 24'h000001, 32'h0000_0000);
    queue_item(OP_SAMPLE, 1'b1, 24'hFFFFFF, 32'hFFFF_FFFF);
    queue_item(OP_ADD, 1'b1, 24'hABCDEF, 32'h0000_0000);
    queue_item(OP_SAMPLE, 1'b1, 24'h000000, 32'h0000_0005);
    queue_item(OP_ADD, 1'b0, 24'h555555, 32'hAAAA_AAAA);
    queue_item(OP_ADD, 1'b1, 24'hAAAAAA, 32'h5555_5555);
    queue_item(OP_SAMPLE, 1'b0, 24'h555555, 32'h8000_0000);
    queue_item(OP_SAMPLE, 1'b1, 24'hAAAAAA, 32'h7FFF_FFFF);
    queue_item(OP_ADD, 1'b0, 24'h0005DC, 32'h0000_0000);
    queue_item(OP_SAMPLE, 1'b0, 24'h000000, 32'h8000_0001);
    queue_item(OP_ADD, 1'b1, 24'hFFFFFF, 32'h0000_0000);
    queue_item(OP_SAMPLE, 1'b1, 24'h000000, 32'h8000_0000);

    // random: bursts of adds, mostly on one direction, then a sample on it after a time step
    clock_ms[0] = 32'h8000_0001;
    clock_ms[1] = 32'h8000_0000;
    while (pending_items.size() < RANDOM_ITEMS) begin
      d = 1'($urandom_range(1));
      burst = $urandom_range(8);
      for (int k = 0; k < burst; k++) begin
        pick = $urandom_range(99);
        if (pick < 10) bytes = 24'hFFFFFF;
        else if (pick < 15) bytes = 24'h000000;
        else if (pick < 35) bytes = 24'($urandom);
        else bytes = 24'($urandom_range(1500, 1));
        dir_sel = ($urandom_range(3) == 0) ? !d : d;
        queue_item(OP_ADD, dir_sel, bytes, $urandom);
      end
      pick = $urandom_range(99);
      if (pick < 5) step = 0;
      else if (pick < 15) step = $urandom;
      else if (pick < 30) step = $urandom_range(5);
      else step = $urandom_range(3000, 1);
      clock_ms[d] = clock_ms[d] + step;
      queue_item(OP_SAMPLE, d, 24'($urandom), clock_ms[d]);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

### files.f
src/etm_pkg.sv
src/ema_throughput_meter_core.sv
sim/testbench.sv
